// ===== rtl/sbbd_pkg.sv =====
// Shared constants, types and helper functions for the spectrum band beat detector.
`default_nettype none
package sbbd_pkg;

  localparam int RING_DEPTH        = 16;
  localparam int BPM_WEIGHT        = 4;
  localparam int FRAMES_PER_WINDOW = 20;
  localparam int BAND_COUNT        = 7;
  localparam int BPM_SCALE         = 30;

  localparam int RING_PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int RING_SUM_W  = 16 + $clog2(RING_DEPTH);
  localparam int RANGE_W     = 22;
  localparam int RECIP_SHIFT = 28;
  localparam int RECIP_W     = 27;

  // Exact reciprocals for the three range divisors over a 22-bit dividend.
  localparam logic [RECIP_W-1:0] RECIP_LOW  = RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd2) / 64'd3);
  localparam logic [RECIP_W-1:0] RECIP_MID  = RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd16) / 64'd17);
  localparam logic [RECIP_W-1:0] RECIP_HIGH = RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd42) / 64'd43);

  localparam logic [15:0] CAL_DEFAULT [16] = '{
    16'd6209, 16'd3991, 16'd37, 16'd34, 16'd56, 16'd146, 16'd146,
    16'd6099, 16'd3886, 16'd116, 16'd141, 16'd213, 16'd649, 16'd649,
    16'd46, 16'd165
  };

  localparam logic [3:0] CAL_AMP_LEFT  = 4'd14;
  localparam logic [3:0] CAL_AMP_RIGHT = 4'd15;

  typedef struct packed {
    logic [2:0]      flags;
    logic [3:0][7:0] bpm;
  } stat_t;

  function automatic logic [15:0] sub_floor(input logic [15:0] v, input logic [15:0] f);
    sub_floor = (v > f) ? v - f : 16'd0;
  endfunction

  function automatic logic [7:0] bpm_update(input logic [7:0] bpm, input logic [4:0] cnt);
    logic [15:0] v;
    v = (16'(bpm) * 16'(BPM_WEIGHT - 1) + 16'(cnt) * 16'(BPM_SCALE)) / 16'(BPM_WEIGHT);
    bpm_update = (v > 16'd255) ? 8'd255 : v[7:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sbbd_lane.sv =====
// One range lane: mean division, history ring update and beat test.
`default_nettype none
module sbbd_lane import sbbd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               go,
  input  wire logic [RANGE_W-1:0] x,
  input  wire logic [RECIP_W-1:0] recip,
  output logic                    beat_valid,
  output logic                    beat
);

  logic [RANGE_W+RECIP_W-1:0] prod;
  logic                       v1;
  logic                       v2;
  logic [15:0]                entry;
  logic [RING_SUM_W-1:0]      sum;
  logic [RING_SUM_W-1:0]      sum_next;
  logic [15:0]                ring [RING_DEPTH];
  logic [RING_PTR_W-1:0]      ptr;
  logic [RING_PTR_W-1:0]      ptr_next;
  logic [15:0]                quot;
  logic [RING_SUM_W-1:0]      avg;
  logic [RING_SUM_W:0]        thr;

  assign quot     = prod[RECIP_SHIFT +: 16];
  assign sum_next = sum - RING_SUM_W'(ring[ptr]) + RING_SUM_W'(quot);
  assign ptr_next = (ptr == RING_PTR_W'(RING_DEPTH - 1)) ? '0 : ptr + 1'b1;
  assign avg      = RING_SUM_W'(sum / RING_DEPTH);
  assign thr      = (RING_SUM_W+1)'(avg) + (RING_SUM_W+1)'(avg >> 1);

  always_ff @(posedge clk) begin
    prod <= x * recip;
    if (v2) begin
      beat <= (RING_SUM_W+1)'(entry) > thr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      beat_valid <= 1'b0;
      ptr        <= '0;
      sum        <= '0;
      for (int i = 0; i < RING_DEPTH; i++) ring[i] <= 16'd0;
    end else begin
      v1         <= go;
      v2         <= v1;
      beat_valid <= v2;
      if (v1) begin
        ring[ptr] <= quot;
        sum       <= sum_next;
        ptr       <= ptr_next;
        entry     <= quot;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sbbd_merge.sv =====
// Merges lane beats into frame flags, beat counts and weighted BPM values.
`default_nettype none
module sbbd_merge import sbbd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       beat_valid,
  input  wire logic [2:0] beats,
  output logic            done,
  output stat_t           stat
);

  logic [3:0][4:0] cnt;
  logic [3:0][4:0] cnt_next;
  logic [4:0]      frames;
  logic [4:0]      frames_next;
  logic [3:0]      hit;

  assign hit         = {|beats, beats};
  assign frames_next = frames + 5'd1;

  always_comb begin
    for (int k = 0; k < 4; k++) cnt_next[k] = cnt[k] + 5'(hit[k]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done   <= 1'b0;
      cnt    <= '0;
      frames <= '0;
      stat   <= '0;
    end else begin
      done <= beat_valid;
      if (beat_valid) begin
        stat.flags <= beats;
        if (frames_next >= 5'(FRAMES_PER_WINDOW)) begin
          for (int k = 0; k < 4; k++) stat.bpm[k] <= bpm_update(stat.bpm[k], cnt_next[k]);
          cnt    <= '0;
          frames <= '0;
        end else begin
          cnt    <= cnt_next;
          frames <= frames_next;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/spectrum_band_beat_detector_unit.sv =====
// Top level of the spectrum band beat detector: band folding, calibration and result burst.
//
//  Channel | Direction | Handshake          | Payload
//  input   | in        | in_valid/in_stall  | func, bins, ADC extremes, calibration word
//  output  | out       | out_valid/out_stall| band_index, bands, amplitudes, beats, BPM, last
//
// One input transaction is taken every cycle while in_stall is low; bins fold
// into the octave band accumulators and range sums in the cycle they arrive. On
// bin 63 a frame snapshot is taken and three lanes run the range division, ring
// update and beat test; the merge stage and the output register follow, and the
// results leave as a burst of seven transactions. While that burst is still pending,
// any transaction offered at bin 63 of the next frame is held off by in_stall.
// Reset is synchronous and restores the default calibration floors, empties
// the rings and counters.
`default_nettype none
module spectrum_band_beat_detector_unit import sbbd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        func,
  input  wire logic [15:0] bin_left,
  input  wire logic [15:0] bin_right,
  input  wire logic [9:0]  adc_min_left,
  input  wire logic [9:0]  adc_max_left,
  input  wire logic [9:0]  adc_min_right,
  input  wire logic [9:0]  adc_max_right,
  input  wire logic [3:0]  calib_index,
  input  wire logic [15:0] calib_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       band_index,
  output logic [15:0]      band_left,
  output logic [15:0]      band_right,
  output logic [9:0]       amplitude_left,
  output logic [9:0]       amplitude_right,
  output logic [2:0]       beat_flags,
  output logic [7:0]       bpm_low,
  output logic [7:0]       bpm_mid,
  output logic [7:0]       bpm_high,
  output logic [7:0]       bpm_any,
  output logic             last
);

  localparam logic [5:0] LAST_BIN  = 6'd63;
  localparam logic [2:0] LAST_BAND = 3'(BAND_COUNT - 1);

  logic [5:0]         bin_counter;
  logic [20:0]        accum_left;
  logic [20:0]        accum_right;
  logic [15:0]        hold_left  [BAND_COUNT];
  logic [15:0]        hold_right [BAND_COUNT];
  logic [RANGE_W-1:0] range_accum [3];
  logic [15:0]        cal [16];
  logic [15:0]        snap_left  [BAND_COUNT];
  logic [15:0]        snap_right [BAND_COUNT];
  logic [9:0]         amp_left;
  logic [9:0]         amp_right;
  logic               inflight;
  logic [2:0]         out_idx;

  logic               accept;
  logic               bin_take;
  logic               frame_end;
  logic               band_end;
  logic [2:0]         band;
  logic [20:0]        sum_left;
  logic [20:0]        sum_right;
  logic [15:0]        new_left;
  logic [15:0]        new_right;
  logic [15:0]        half;
  logic [9:0]         raw_left;
  logic [9:0]         raw_right;
  logic [2:0]         lane_valid;
  logic [2:0]         beats;
  logic               merge_done;
  stat_t              stat;

  // Input side: any transaction at bin 63 waits while the previous frame is still out.
  assign in_stall  = (bin_counter == LAST_BIN) && (inflight || out_valid);
  assign accept    = in_valid && !in_stall;
  assign bin_take  = accept && !func;
  assign frame_end = bin_take && (bin_counter == LAST_BIN);

  assign sum_left  = accum_left + 21'(bin_left);
  assign sum_right = accum_right + 21'(bin_right);
  assign band_end  = (bin_counter & (bin_counter + 6'd1)) == 6'd0;
  assign half      = 16'((17'(bin_left) + 17'(bin_right)) >> 1);

  // Octave band that closes at this bin, with its mean shift.
  always_comb begin
    case (bin_counter)
      6'd0: begin
        band = 3'd0; new_left = sum_left[15:0]; new_right = sum_right[15:0];
      end
      6'd1: begin
        band = 3'd1; new_left = sum_left[15:0]; new_right = sum_right[15:0];
      end
      6'd3: begin
        band = 3'd2; new_left = sum_left[16:1]; new_right = sum_right[16:1];
      end
      6'd7: begin
        band = 3'd3; new_left = sum_left[17:2]; new_right = sum_right[17:2];
      end
      6'd15: begin
        band = 3'd4; new_left = sum_left[18:3]; new_right = sum_right[18:3];
      end
      6'd31: begin
        band = 3'd5; new_left = sum_left[19:4]; new_right = sum_right[19:4];
      end
      default: begin
        band = LAST_BAND; new_left = sum_left[20:5]; new_right = sum_right[20:5];
      end
    endcase
  end

  // Peak-to-peak amplitude, zero when the extremes arrive inverted.
  assign raw_left  = (adc_max_left >= adc_min_left) ? adc_max_left - adc_min_left : 10'd0;
  assign raw_right = (adc_max_right >= adc_min_right) ? adc_max_right - adc_min_right : 10'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_counter <= '0;
      accum_left  <= '0;
      accum_right <= '0;
      for (int k = 0; k < 3; k++) range_accum[k] <= '0;
      for (int i = 0; i < 16; i++) cal[i] <= CAL_DEFAULT[i];
    end else begin
      if (accept && func) begin
        cal[calib_index] <= calib_value;
      end
      if (bin_take) begin
        bin_counter <= bin_counter + 6'd1;
        if (band_end) begin
          accum_left  <= '0;
          accum_right <= '0;
        end else begin
          accum_left  <= sum_left;
          accum_right <= sum_right;
        end
        if (frame_end) begin
          for (int k = 0; k < 3; k++) range_accum[k] <= '0;
        end else if (bin_counter <= 6'd2) begin
          range_accum[0] <= range_accum[0] + RANGE_W'(half);
        end else if (bin_counter <= 6'd19) begin
          range_accum[1] <= range_accum[1] + RANGE_W'(half);
        end else begin
          range_accum[2] <= range_accum[2] + RANGE_W'(half);
        end
      end
    end
  end

  // Band holds and the frame snapshot with floors applied.
  always_ff @(posedge clk) begin
    if (bin_take && band_end) begin
      hold_left[band]  <= new_left;
      hold_right[band] <= new_right;
    end
    if (frame_end) begin
      for (int k = 0; k < BAND_COUNT - 1; k++) begin
        snap_left[k]  <= sub_floor(hold_left[k], cal[k]);
        snap_right[k] <= sub_floor(hold_right[k], cal[k + BAND_COUNT]);
      end
      snap_left[BAND_COUNT-1]  <= sub_floor(new_left, cal[BAND_COUNT - 1]);
      snap_right[BAND_COUNT-1] <= sub_floor(new_right, cal[2 * BAND_COUNT - 1]);
      amp_left  <= 10'(sub_floor(16'(raw_left), cal[CAL_AMP_LEFT]));
      amp_right <= 10'(sub_floor(16'(raw_right), cal[CAL_AMP_RIGHT]));
    end
  end

  sbbd_lane u_lane_low (
    .clk        (clk),
    .rst        (rst),
    .go         (frame_end),
    .x          (range_accum[0]),
    .recip      (RECIP_LOW),
    .beat_valid (lane_valid[0]),
    .beat       (beats[0])
  );

  sbbd_lane u_lane_mid (
    .clk        (clk),
    .rst        (rst),
    .go         (frame_end),
    .x          (range_accum[1]),
    .recip      (RECIP_MID),
    .beat_valid (lane_valid[1]),
    .beat       (beats[1])
  );

  sbbd_lane u_lane_high (
    .clk        (clk),
    .rst        (rst),
    .go         (frame_end),
    .x          (range_accum[2]),
    .recip      (RECIP_HIGH),
    .beat_valid (lane_valid[2]),
    .beat       (beats[2])
  );

  // All lanes run in lockstep, so their valid bits agree.
  sbbd_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .beat_valid (&lane_valid),
    .beats      (beats),
    .done       (merge_done),
    .stat       (stat)
  );

  // Result burst: seven transactions walk the snapshot by band index.
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight  <= 1'b0;
      out_valid <= 1'b0;
      out_idx   <= '0;
    end else begin
      if (frame_end) begin
        inflight <= 1'b1;
      end else if (merge_done) begin
        inflight <= 1'b0;
      end
      if (merge_done) begin
        out_valid <= 1'b1;
        out_idx   <= '0;
      end else if (out_valid && !out_stall) begin
        if (out_idx == LAST_BAND) begin
          out_valid <= 1'b0;
          out_idx   <= '0;
        end else begin
          out_idx <= out_idx + 3'd1;
        end
      end
    end
  end

  assign band_index      = out_idx;
  assign band_left       = snap_left[out_idx];
  assign band_right      = snap_right[out_idx];
  assign amplitude_left  = amp_left;
  assign amplitude_right = amp_right;
  assign beat_flags      = stat.flags;
  assign bpm_low         = stat.bpm[0];
  assign bpm_mid         = stat.bpm[1];
  assign bpm_high        = stat.bpm[2];
  assign bpm_any         = stat.bpm[3];
  assign last            = (out_idx == LAST_BAND);

endmodule
`default_nettype wire
